FILE: sv/wmm_pkg.sv
`timescale 1ns / 1ps
package wmm_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 11;
  // Wide enough for the exact sum of up to 2047 signed 32-bit samples
  localparam int SUM_W  = DATA_W + CNT_W;

  localparam logic [CNT_W-1:0] RESET_LEN = 11'd1024;

  typedef enum logic [0:0] {
    OP_ADD   = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [DATA_W-1:0]  sample;
  } item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ_OLD,
    S_SUB_OLD,
    S_WRITE,
    S_SCAN,
    S_DIV,
    S_DONE
  } state_t;

  function automatic logic signed [SUM_W-1:0] sext_sum(input logic [DATA_W-1:0] v);
    sext_sum = {{(SUM_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

endpackage

FILE: sv/wmm_ram.sv
`timescale 1ns / 1ps
module wmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/wmm_div.sv
`timescale 1ns / 1ps
module wmm_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [wmm_pkg::SUM_W-1:0]  dividend,
  input  logic [wmm_pkg::CNT_W-1:0]  divisor,
  output logic                       done,
  output logic [wmm_pkg::SUM_W-1:0]  quotient
);
  import wmm_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;
  logic [CNT_W:0]    trial;
  logic              fits;

  // Restoring division, one quotient bit per cycle, MSB first
  always_comb begin
    trial = {rem, quotient[SUM_W-1]};
    fits  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        steps    <= STEP_W'(SUM_W);
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        if (fits) begin
          rem <= CNT_W'(trial - {1'b0, dvs});
        end else begin
          rem <= trial[CNT_W-1:0];
        end
        quotient <= {quotient[SUM_W-2:0], fits};
        steps    <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/wmm_front.sv
`timescale 1ns / 1ps
module wmm_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd,
  input  logic [wmm_pkg::DATA_W-1:0] sample_y,
  input  logic                       sample_valid,
  output logic                       sample_stall,
  output wmm_pkg::item_t             q_item,
  output logic                       q_valid,
  input  logic                       q_pop
);
  import wmm_pkg::*;

  item_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  logic        push;
  item_t       incoming;

  always_comb begin
    incoming.op     = cmd ? OP_CLEAR : OP_ADD;
    incoming.sample = sample_y;
    sample_stall    = fill == 2'd2;
    push            = sample_valid && !sample_stall;
    q_valid         = fill != 2'd0;
    q_item          = slots[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= incoming;
        wr_ptr        <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: sv/wmm_back.sv
`timescale 1ns / 1ps
module wmm_back #(
  parameter int MAX_DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        len_we,
  input  logic [wmm_pkg::CNT_W-1:0]   len_data,
  input  wmm_pkg::item_t              q_item,
  input  logic                        q_valid,
  output logic                        q_pop,
  output logic signed [wmm_pkg::DATA_W-1:0] min_y,
  output logic signed [wmm_pkg::DATA_W-1:0] max_y,
  output logic signed [wmm_pkg::DATA_W-1:0] mean_y,
  output logic [wmm_pkg::CNT_W-1:0]   sample_count,
  output logic                        result_valid,
  input  logic                        result_stall
);
  import wmm_pkg::*;

  localparam int AW = $clog2(MAX_DEPTH);

  state_t                   state, state_next;
  logic [CNT_W-1:0]         window_len;
  logic [CNT_W-1:0]         eff_len;
  logic [AW-1:0]            wp;
  logic [AW-1:0]            wp_sel;
  logic [AW-1:0]            wp_wrap;
  logic [31:0]              wp_inc;
  logic [CNT_W-1:0]         held;
  logic signed [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]         sum_mag;
  logic [AW-1:0]            cur_wp;
  logic [DATA_W-1:0]        cur_sample;
  logic [CNT_W-1:0]         scan_i;
  logic                     scan_issue;
  logic                     scan_done;
  logic                     pend;
  logic                     first;
  logic signed [DATA_W-1:0] mn, mx;
  logic signed [DATA_W-1:0] rd_val;
  logic                     full;

  logic                     rd_en, wr_en;
  logic [AW-1:0]            rd_addr;
  logic [DATA_W-1:0]        rd_data;
  logic                     div_start, div_done;
  logic [SUM_W-1:0]         quo;
  logic                     out_load;

  wmm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DEPTH)) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (cur_wp),
    .wdata (cur_sample),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  wmm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (held),
    .done     (div_done),
    .quotient (quo)
  );

  // Length zero acts as one, a length past the store depth as the depth
  always_comb begin
    if (window_len == '0) begin
      eff_len = CNT_W'(1);
    end else if (32'(window_len) > 32'(MAX_DEPTH)) begin
      eff_len = CNT_W'(MAX_DEPTH);
    end else begin
      eff_len = window_len;
    end
    wp_sel     = (32'(wp) >= 32'(eff_len)) ? '0 : wp;
    wp_inc     = 32'(cur_wp) + 32'd1;
    wp_wrap    = (wp_inc >= 32'(eff_len)) ? '0 : AW'(wp_inc);
    full       = held >= eff_len;
    sum_mag    = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    scan_issue = (state == S_SCAN) && (scan_i < held);
    scan_done  = (scan_i >= held) && !pend;
    rd_val     = $signed(rd_data);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          if (q_item.op == OP_CLEAR) begin
            state_next = S_DONE;
          end else if (full) begin
            state_next = S_READ_OLD;
          end else begin
            state_next = S_WRITE;
          end
        end
      end
      S_READ_OLD: state_next = S_SUB_OLD;
      S_SUB_OLD:  state_next = S_WRITE;
      S_WRITE:    state_next = S_SCAN;
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!result_valid || !result_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state == S_IDLE) && q_valid;
    rd_en     = (state == S_READ_OLD) || scan_issue;
    rd_addr   = (state == S_READ_OLD) ? cur_wp : AW'(scan_i);
    wr_en     = state == S_WRITE;
    div_start = (state == S_SCAN) && scan_done;
    out_load  = (state == S_DONE) && (!result_valid || !result_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      window_len   <= RESET_LEN;
      wp           <= '0;
      held         <= '0;
      sum          <= '0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= scan_issue;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur_sample <= q_item.sample;
            cur_wp     <= wp_sel;
            if (q_item.op == OP_CLEAR) begin
              wp   <= '0;
              held <= '0;
              sum  <= '0;
            end else if (!full) begin
              held <= held + 1'b1;
            end
          end
        end
        S_SUB_OLD: begin
          sum  <= sum - sext_sum(rd_data);
          held <= eff_len;
        end
        S_WRITE: begin
          sum    <= sum + sext_sum(cur_sample);
          wp     <= wp_wrap;
          scan_i <= '0;
          first  <= 1'b1;
        end
        S_SCAN: begin
          if (scan_issue) begin
            scan_i <= scan_i + 1'b1;
          end
          if (pend) begin
            first <= 1'b0;
            if (first || rd_val < mn) begin
              mn <= rd_val;
            end
            if (first || rd_val > mx) begin
              mx <= rd_val;
            end
          end
        end
        default: begin
        end
      endcase

      if (out_load) begin
        result_valid <= 1'b1;
        sample_count <= held;
        if (held == '0) begin
          min_y  <= '0;
          max_y  <= '0;
          mean_y <= '0;
        end else begin
          min_y  <= mn;
          max_y  <= mx;
          mean_y <= sum[SUM_W-1] ? DATA_W'(-quo) : DATA_W'(quo);
        end
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      // Any length write empties the window
      if (len_we) begin
        window_len <= len_data;
        wp         <= '0;
        held       <= '0;
        sum        <= '0;
      end
    end
  end

endmodule

FILE: sv/window_min_max_mean.sv
// Sliding-window statistics over signed Q16.16 samples. Each request carries
// cmd (0 adds sample_y, 1 clears the window) and yields exactly one result:
// min_y, max_y, mean_y (sum / count, truncated toward zero) and sample_count,
// all zero while the window is empty. Writing window_len empties the window;
// a length of 0 acts as 1 and one above MAX_DEPTH acts as MAX_DEPTH. The
// min/max walk reads every held sample through the single read port of the
// sample RAM, and the mean comes from a 43-step bit-serial divider. A
// two-entry queue takes new requests while the back end works, and a result
// register holds the finished result until taken.
`timescale 1ns / 1ps
module window_min_max_mean #(
  parameter int MAX_DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              window_len_we,
  input  logic [wmm_pkg::CNT_W-1:0]         window_len,
  input  logic                              cmd,
  input  logic signed [wmm_pkg::DATA_W-1:0] sample_y,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  output logic signed [wmm_pkg::DATA_W-1:0] min_y,
  output logic signed [wmm_pkg::DATA_W-1:0] max_y,
  output logic signed [wmm_pkg::DATA_W-1:0] mean_y,
  output logic [wmm_pkg::CNT_W-1:0]         sample_count,
  output logic                              result_valid,
  input  logic                              result_stall
);
  import wmm_pkg::*;

  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  // Front end: classify and queue requests
  wmm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sample_y     (sample_y),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .q_item       (q_item),
    .q_valid      (q_valid),
    .q_pop        (q_pop)
  );

  // Back end: ring update, min/max walk, serial divide, result register
  wmm_back #(.MAX_DEPTH(MAX_DEPTH)) u_back (
    .clk          (clk),
    .rst          (rst),
    .len_we       (window_len_we),
    .len_data     (window_len),
    .q_item       (q_item),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .min_y        (min_y),
    .max_y        (max_y),
    .mean_y       (mean_y),
    .sample_count (sample_count),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

`ifndef SYNTHESIS
  // An empty window reports all statistics as zero
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && sample_count == '0) |-> (min_y == '0 && max_y == '0 && mean_y == '0))
    else $error("empty window with nonzero statistics");

  // The truncated mean lies between the minimum and the maximum
  a_mean_bounded: assert property (@(posedge clk) disable iff (rst)
    (result_valid && sample_count != '0) |-> (min_y <= mean_y && mean_y <= max_y))
    else $error("mean outside min/max range");

  // Input stalls only when the queue holds requests for the back end
  a_stall_queue: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> q_valid)
    else $error("input stalled with empty queue");
`endif

endmodule
